[rtl/osr_pkg.sv]
// package for the online segment regression log-likelihood block
// holds constants, status codes, state codes and unit request types; no dependencies
package osr_pkg;

   localparam int MAX_SEGMENT = 4096;
   localparam int CNT_W = 13;
   localparam int MUL_W = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int DVD_W = 128;
   localparam int DVS_W = 64;
   localparam int ITER_W = 8;

   localparam logic [CNT_W-1:0] MIN_LENGTH_RESET = CNT_W'(2);
   localparam logic [CNT_W-1:0] MAX_SEGMENT_CNT = CNT_W'(MAX_SEGMENT);
   localparam logic signed [MUL_W-1:0] ONE_PLUS_LN2PI_Q16 = 33'sd185983;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [DVD_W-1:0] QUOT_CAP = DVD_W'(1) << 62;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_DEGENERATE = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   typedef enum logic [28:0] {
      ST_IDLE      = 29'h0000_0001,
      ST_CHECK     = 29'h0000_0002,
      ST_DIVX_GO   = 29'h0000_0004,
      ST_DIVX_WAIT = 29'h0000_0008,
      ST_DIVY_GO   = 29'h0000_0010,
      ST_DIVY_WAIT = 29'h0000_0020,
      ST_MULX      = 29'h0000_0040,
      ST_MULY      = 29'h0000_0080,
      ST_MULP      = 29'h0000_0100,
      ST_DIVP_GO   = 29'h0000_0200,
      ST_DIVP_WAIT = 29'h0000_0400,
      ST_DIVM_GO   = 29'h0000_0800,
      ST_DIVM_WAIT = 29'h0000_1000,
      ST_SQ0       = 29'h0000_2000,
      ST_SQ1       = 29'h0000_4000,
      ST_SQ2       = 29'h0000_8000,
      ST_SQ3       = 29'h0001_0000,
      ST_D0        = 29'h0002_0000,
      ST_D1        = 29'h0004_0000,
      ST_DIVQ_GO   = 29'h0008_0000,
      ST_DIVQ_WAIT = 29'h0010_0000,
      ST_NORM      = 29'h0020_0000,
      ST_LOGM      = 29'h0040_0000,
      ST_LOGS      = 29'h0080_0000,
      ST_LNMUL     = 29'h0100_0000,
      ST_LNRND     = 29'h0200_0000,
      ST_LLMUL     = 29'h0400_0000,
      ST_LLFIN     = 29'h0800_0000,
      ST_EMIT      = 29'h1000_0000
   } state_type;

   typedef struct packed {
      logic                     load;
      logic signed [MUL_W-1:0]  a;
      logic signed [MUL_W-1:0]  b;
   } mul_req_type;

   typedef struct packed {
      logic                     start;
      logic [DVD_W-1:0]         dividend;
      logic [DVS_W-1:0]         divisor;
      logic [ITER_W-1:0]        iter;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic [DVD_W-1:0]         quotient;
   } div_rsp_type;

   typedef struct packed {
      logic signed [31:0]       log_likelihood;
      logic [CNT_W-1:0]         segment_length;
      logic [1:0]               status;
   } result_type;

endpackage

[rtl/osr_if.sv]
// valid/ready channel interfaces for sample pairs and results
// depends on osr_pkg for widths
interface osr_req_if;
   import osr_pkg::*;
   logic               valid;
   logic               ready;
   logic signed [15:0] x_sample;
   logic signed [15:0] y_sample;
   logic               segment_start;
   modport source (output valid, x_sample, y_sample, segment_start, input ready);
   modport sink (input valid, x_sample, y_sample, segment_start, output ready);
endinterface

interface osr_rsp_if;
   import osr_pkg::*;
   logic               valid;
   logic               ready;
   logic signed [31:0] log_likelihood;
   logic [CNT_W-1:0]   segment_length;
   logic [1:0]         status;
   modport source (output valid, log_likelihood, segment_length, status, input ready);
   modport sink (input valid, log_likelihood, segment_length, status, output ready);
endinterface

[rtl/osr_mul.sv]
// shared signed multiplier with registered product
// depends on osr_pkg
module osr_mul
   import osr_pkg::*;
(
   input  logic                      clock,
   input  mul_req_type               mul_req,
   output logic signed [PROD_W-1:0]  prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = prod_ff;
      if (mul_req.load) begin
         prod_in = PROD_W'(mul_req.a) * PROD_W'(mul_req.b);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

[rtl/osr_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on osr_pkg; dividend is left aligned for the requested bit count
module osr_div
   import osr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_req_type  div_req,
   output div_rsp_type  div_rsp
);

   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    shifted;
   logic [DVS_W:0]    diff;
   logic              fits;

   always_comb begin
      shifted = {rem_ff, dvd_ff[DVD_W-1]};
      diff = shifted - {1'b0, dvs_ff};
      fits = (shifted >= {1'b0, dvs_ff});
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in = '0;
         dvd_in = div_req.dividend;
         quo_in = '0;
         dvs_in = div_req.divisor;
         cnt_in = div_req.iter;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - ITER_W'(1);
         if (cnt_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[rtl/osr_seq.sv]
// sequencer and accumulator state: welford update, residual variance, log and scaling
// depends on osr_pkg; drives the shared multiplier and divider
module osr_seq
   import osr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [15:0]        x_sample,
   input  logic signed [15:0]        y_sample,
   input  logic                      segment_start,
   input  logic [CNT_W-1:0]          min_length,
   input  logic                      out_free,
   output logic                      emit,
   output result_type                result,
   output mul_req_type               mul_req,
   input  logic signed [PROD_W-1:0]  prod,
   output div_req_type               div_req,
   input  div_rsp_type               div_rsp
);

   state_type state_ff, state_in;

   logic signed [39:0] mean_x_ff, mean_x_in, mean_y_ff, mean_y_in;
   logic signed [63:0] moment_x_ff, moment_x_in, moment_y_ff, moment_y_in;
   logic signed [63:0] comoment_ff, comoment_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic signed [23:0] xs_ff, xs_in, ys_ff, ys_in;
   logic signed [40:0] dpx_ff, dpx_in, dpy_ff, dpy_in;
   logic signed [PROD_W-1:0] p_ff, p_in;
   logic [63:0]        myl_ff, myl_in;
   logic [127:0]       acc_ff, acc_in;
   logic [63:0]        d_ff, d_in;
   logic [63:0]        sig_ff, sig_in;
   logic [5:0]         e_ff, e_in;
   logic [30:0]        m_ff, m_in;
   logic [15:0]        frac_ff, frac_in;
   logic [3:0]         it_ff, it_in;
   logic signed [MUL_W-1:0] sum_ff, sum_in;
   result_type         res_ff, res_in;

   logic [CNT_W-1:0]   thr;
   logic signed [40:0] dnx, dny, dpx_abs, dpy_abs;
   logic signed [PROD_W-1:0] p_abs, p_q, p_red, prod_sh, ln_full, ll_neg, ll_half;
   logic signed [40:0] q_signed;
   logic [63:0]        c_abs;
   logic [127:0]       q_cap;
   logic signed [64:0] sig_diff;
   logic [31:0]        sq;
   logic signed [6:0]  e_off;
   logic signed [22:0] l2;

   always_comb begin
      thr = (min_length == '0) ? CNT_W'(1) : min_length;
      dnx = 41'(xs_ff) - 41'(mean_x_ff);
      dny = 41'(ys_ff) - 41'(mean_y_ff);
      dpx_abs = dpx_ff[40] ? -dpx_ff : dpx_ff;
      dpy_abs = dpy_ff[40] ? -dpy_ff : dpy_ff;
      p_abs = prod[PROD_W-1] ? -prod : prod;
      prod_sh = prod >>> 16;
      q_signed = $signed({9'b0, div_rsp.quotient[31:0]});
      p_q = $signed({14'b0, div_rsp.quotient[51:0]});
      if (p_ff[PROD_W-1]) begin
         p_q = -p_q;
      end
      p_red = (p_ff - p_q) >>> 16;
      c_abs = comoment_ff[63] ? 64'(-comoment_ff) : 64'(comoment_ff);
      q_cap = (div_rsp.quotient > QUOT_CAP) ? QUOT_CAP : div_rsp.quotient;
      sig_diff = $signed({1'b0, myl_ff}) - $signed({1'b0, q_cap[63:0]});
      sq = prod[61:30];
      e_off = $signed({1'b0, e_ff}) - 7'sd16;
      l2 = $signed({e_off, frac_ff});
      ln_full = (prod + (PROD_W'(1) <<< 31)) >>> 32;
      ll_neg = -prod;
      ll_half = ll_neg >>> 1;
   end

   always_comb begin
      state_in = state_ff;
      mean_x_in = mean_x_ff;
      mean_y_in = mean_y_ff;
      moment_x_in = moment_x_ff;
      moment_y_in = moment_y_ff;
      comoment_in = comoment_ff;
      count_in = count_ff;
      xs_in = xs_ff;
      ys_in = ys_ff;
      dpx_in = dpx_ff;
      dpy_in = dpy_ff;
      p_in = p_ff;
      myl_in = myl_ff;
      acc_in = acc_ff;
      d_in = d_ff;
      sig_in = sig_ff;
      e_in = e_ff;
      m_in = m_ff;
      frac_in = frac_ff;
      it_in = it_ff;
      sum_in = sum_ff;
      res_in = res_ff;
      mul_req = '0;
      div_req = '0;
      emit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               xs_in = {x_sample, 8'b0};
               ys_in = {y_sample, 8'b0};
               if (segment_start) begin
                  mean_x_in = '0;
                  mean_y_in = '0;
                  moment_x_in = '0;
                  moment_y_in = '0;
                  comoment_in = '0;
                  count_in = '0;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (count_ff >= MAX_SEGMENT_CNT) begin
               // segment full: sample dropped, state kept
               if (thr > MAX_SEGMENT_CNT) begin
                  state_in = ST_IDLE;
               end else begin
                  res_in.log_likelihood = '0;
                  res_in.segment_length = MAX_SEGMENT_CNT;
                  res_in.status = STATUS_SATURATED;
                  state_in = ST_EMIT;
               end
            end else begin
               count_in = count_ff + CNT_W'(1);
               dpx_in = 41'(xs_ff) - 41'(mean_x_ff);
               dpy_in = 41'(ys_ff) - 41'(mean_y_ff);
               state_in = ST_DIVX_GO;
            end
         end
         ST_DIVX_GO: begin
            div_req.start = 1'b1;
            div_req.dividend = {dpx_abs[31:0], 96'b0};
            div_req.divisor = 64'(count_ff);
            div_req.iter = ITER_W'(32);
            state_in = ST_DIVX_WAIT;
         end
         ST_DIVX_WAIT: begin
            if (div_rsp.done) begin
               mean_x_in = mean_x_ff + (dpx_ff[40] ? -q_signed[39:0] : q_signed[39:0]);
               state_in = ST_DIVY_GO;
            end
         end
         ST_DIVY_GO: begin
            div_req.start = 1'b1;
            div_req.dividend = {dpy_abs[31:0], 96'b0};
            div_req.divisor = 64'(count_ff);
            div_req.iter = ITER_W'(32);
            state_in = ST_DIVY_WAIT;
         end
         ST_DIVY_WAIT: begin
            if (div_rsp.done) begin
               mean_y_in = mean_y_ff + (dpy_ff[40] ? -q_signed[39:0] : q_signed[39:0]);
               state_in = ST_MULX;
            end
         end
         ST_MULX: begin
            mul_req.load = 1'b1;
            mul_req.a = dpx_ff[32:0];
            mul_req.b = dnx[32:0];
            state_in = ST_MULY;
         end
         ST_MULY: begin
            moment_x_in = moment_x_ff + prod_sh[63:0];
            mul_req.load = 1'b1;
            mul_req.a = dpy_ff[32:0];
            mul_req.b = dny[32:0];
            state_in = ST_MULP;
         end
         ST_MULP: begin
            moment_y_in = moment_y_ff + prod_sh[63:0];
            mul_req.load = 1'b1;
            mul_req.a = dpx_ff[32:0];
            mul_req.b = dpy_ff[32:0];
            state_in = ST_DIVP_GO;
         end
         ST_DIVP_GO: begin
            p_in = prod;
            div_req.start = 1'b1;
            div_req.dividend = {p_abs[51:0], 76'b0};
            div_req.divisor = 64'(count_ff);
            div_req.iter = ITER_W'(52);
            state_in = ST_DIVP_WAIT;
         end
         ST_DIVP_WAIT: begin
            if (div_rsp.done) begin
               comoment_in = comoment_ff + p_red[63:0];
               if (count_ff < thr) begin
                  state_in = ST_IDLE;
               end else if (moment_x_ff <= 64'sd0) begin
                  res_in.log_likelihood = '0;
                  res_in.segment_length = count_ff;
                  res_in.status = STATUS_DEGENERATE;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_DIVM_GO;
               end
            end
         end
         ST_DIVM_GO: begin
            div_req.start = 1'b1;
            div_req.dividend = {moment_y_ff, 64'b0};
            div_req.divisor = 64'(count_ff);
            div_req.iter = ITER_W'(64);
            state_in = ST_DIVM_WAIT;
         end
         ST_DIVM_WAIT: begin
            if (div_rsp.done) begin
               myl_in = div_rsp.quotient[63:0];
               state_in = ST_SQ0;
            end
         end
         ST_SQ0: begin
            mul_req.load = 1'b1;
            mul_req.a = {1'b0, c_abs[31:0]};
            mul_req.b = {1'b0, c_abs[31:0]};
            state_in = ST_SQ1;
         end
         ST_SQ1: begin
            acc_in = {64'b0, prod[63:0]};
            mul_req.load = 1'b1;
            mul_req.a = {1'b0, c_abs[31:0]};
            mul_req.b = {1'b0, c_abs[63:32]};
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            acc_in = acc_ff + ({64'b0, prod[63:0]} << 33);
            mul_req.load = 1'b1;
            mul_req.a = {1'b0, c_abs[63:32]};
            mul_req.b = {1'b0, c_abs[63:32]};
            state_in = ST_SQ3;
         end
         ST_SQ3: begin
            acc_in = acc_ff + {prod[63:0], 64'b0};
            mul_req.load = 1'b1;
            mul_req.a = {1'b0, moment_x_ff[31:0]};
            mul_req.b = 33'(count_ff);
            state_in = ST_D0;
         end
         ST_D0: begin
            d_in = prod[63:0];
            mul_req.load = 1'b1;
            mul_req.a = {1'b0, moment_x_ff[63:32]};
            mul_req.b = 33'(count_ff);
            state_in = ST_D1;
         end
         ST_D1: begin
            d_in = d_ff + {prod[31:0], 32'b0};
            state_in = ST_DIVQ_GO;
         end
         ST_DIVQ_GO: begin
            div_req.start = 1'b1;
            div_req.dividend = acc_ff;
            div_req.divisor = d_ff;
            div_req.iter = ITER_W'(128);
            state_in = ST_DIVQ_WAIT;
         end
         ST_DIVQ_WAIT: begin
            if (div_rsp.done) begin
               if (sig_diff <= 65'sd0) begin
                  res_in.log_likelihood = '0;
                  res_in.segment_length = count_ff;
                  res_in.status = STATUS_DEGENERATE;
                  state_in = ST_EMIT;
               end else begin
                  sig_in = sig_diff[63:0];
                  e_in = 6'd63;
                  state_in = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            if (sig_ff[63]) begin
               m_in = sig_ff[63:33];
               frac_in = '0;
               it_in = '0;
               state_in = ST_LOGM;
            end else begin
               sig_in = {sig_ff[62:0], 1'b0};
               e_in = e_ff - 6'd1;
            end
         end
         ST_LOGM: begin
            mul_req.load = 1'b1;
            mul_req.a = {2'b0, m_ff};
            mul_req.b = {2'b0, m_ff};
            state_in = ST_LOGS;
         end
         ST_LOGS: begin
            if (sq[31]) begin
               m_in = sq[31:1];
               frac_in[4'd15 - it_ff] = 1'b1;
            end else begin
               m_in = sq[30:0];
            end
            it_in = it_ff + 4'd1;
            state_in = (it_ff == 4'd15) ? ST_LNMUL : ST_LOGM;
         end
         ST_LNMUL: begin
            mul_req.load = 1'b1;
            mul_req.a = 33'(l2);
            mul_req.b = {1'b0, LN2_Q32};
            state_in = ST_LNRND;
         end
         ST_LNRND: begin
            sum_in = ONE_PLUS_LN2PI_Q16 + ln_full[MUL_W-1:0];
            state_in = ST_LLMUL;
         end
         ST_LLMUL: begin
            mul_req.load = 1'b1;
            mul_req.a = 33'(count_ff);
            mul_req.b = sum_ff;
            state_in = ST_LLFIN;
         end
         ST_LLFIN: begin
            if (ll_half > PROD_W'(32'sh7FFF_FFFF)) begin
               res_in.log_likelihood = 32'sh7FFF_FFFF;
            end else if (ll_half < -(PROD_W'(1) <<< 31)) begin
               res_in.log_likelihood = 32'sh8000_0000;
            end else begin
               res_in.log_likelihood = ll_half[31:0];
            end
            res_in.segment_length = count_ff;
            res_in.status = STATUS_OK;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mean_x_ff <= '0;
         mean_y_ff <= '0;
         moment_x_ff <= '0;
         moment_y_ff <= '0;
         comoment_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         mean_x_ff <= mean_x_in;
         mean_y_ff <= mean_y_in;
         moment_x_ff <= moment_x_in;
         moment_y_ff <= moment_y_in;
         comoment_ff <= comoment_in;
         count_ff <= count_in;
      end
      xs_ff <= xs_in;
      ys_ff <= ys_in;
      dpx_ff <= dpx_in;
      dpy_ff <= dpy_in;
      p_ff <= p_in;
      myl_ff <= myl_in;
      acc_ff <= acc_in;
      d_ff <= d_in;
      sig_ff <= sig_in;
      e_ff <= e_in;
      m_ff <= m_in;
      frac_ff <= frac_in;
      it_ff <= it_in;
      sum_ff <= sum_in;
      res_ff <= res_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign result = res_ff;

endmodule

[rtl/online_segment_regression_loglik.sv]
// results: degenerate when the x spread is zero or the residual variance is not positive,
// full after the normalize shift and log, saturated with a zero value once the segment is full;
// the shared divider gives one quotient bit per cycle over 32+32+52+64+128 bits, the log
// runs a 16-step squaring loop, and a result may wait on the consumer before it is emitted
// throughput: one sample at a time, the next is taken once the sequencer is back in idle;
// reset: synchronous, min_length = 2
module online_segment_regression_loglik
   import osr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   osr_req_if.sink           req_if,
   osr_rsp_if.source         rsp_if,
   input  logic              csr_write_enable,
   input  logic [CNT_W-1:0]  csr_write_data
);

   // configuration register
   logic [CNT_W-1:0] min_length_ff, min_length_in;

   // result holding register, parts the sequencer from the consumer
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff, rsp_data_in;

   logic             out_free;
   logic             emit;
   result_type       result;
   mul_req_type      mul_req;
   logic signed [PROD_W-1:0] prod;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   // slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      min_length_in = min_length_ff;
      if (csr_write_enable) begin
         min_length_in = csr_write_data;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = result;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LENGTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_length_ff <= min_length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // sequencer: welford update, variance, log, scaling
   osr_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .x_sample      (req_if.x_sample),
      .y_sample      (req_if.y_sample),
      .segment_start (req_if.segment_start),
      .min_length    (min_length_ff),
      .out_free      (out_free),
      .emit          (emit),
      .result        (result),
      .mul_req       (mul_req),
      .prod          (prod),
      .div_req       (div_req),
      .div_rsp       (div_rsp)
   );

   // shared multiplier, one product per issue
   osr_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   // shared bit-serial divider
   osr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.log_likelihood = rsp_data_ff.log_likelihood;
   assign rsp_if.segment_length = rsp_data_ff.segment_length;
   assign rsp_if.status = rsp_data_ff.status;

endmodule

[rtl/osr_checker.sv]
// port-level checks for the segment regression log-likelihood block
// depends on osr_pkg; bound to the top level below
module osr_checker
   import osr_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] log_likelihood,
   input logic [CNT_W-1:0]   segment_length,
   input logic [1:0]         status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(log_likelihood) && $stable(status))
      else $error("result changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STATUS_SATURATED |->
         log_likelihood == 32'sd0 && segment_length == MAX_SEGMENT_CNT)
      else $error("bad saturated result");

   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (status != STATUS_DEGENERATE || log_likelihood == 32'sd0)
         && status <= STATUS_SATURATED && segment_length != '0)
      else $error("bad degenerate or status code");

endmodule

bind online_segment_regression_loglik osr_checker u_osr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .log_likelihood (rsp_if.log_likelihood),
   .segment_length (rsp_if.segment_length),
   .status         (rsp_if.status)
);
